// ===== hw/rtl/skhm_pkg.sv =====
`timescale 1ns / 1ps

package skhm_pkg;

  localparam int unsigned KEY_WORDS = 8;
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_OCC,
    S_CMP,
    S_WRITE,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_step;
    logic    byte_take;
    logic    start;
    logic    mod_step;
    logic    occ_rd;
    logic    cmp_step;
    logic    probe_next;
    logic    wr_step;
    logic    out_load;
    status_t res_status;
    logic    res_use_val;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic word_last;
    logic probe_last;
    logic occ;
    logic match;
    logic req_query;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/skhm_ctrl.sv =====
`timescale 1ns / 1ps

module skhm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_key_byte,
  input  skhm_pkg::sts_t  sts,
  output logic            in_stall,
  output skhm_pkg::cmd_t  cmd
);
  import skhm_pkg::*;

  state_t  state_r, state_nxt;
  status_t res_status_r, res_status_nxt;
  logic    res_use_val_r, res_use_val_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      res_status_r  <= ST_OK;
      res_use_val_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      res_status_r  <= res_status_nxt;
      res_use_val_r <= res_use_val_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    res_status_nxt  = res_status_r;
    res_use_val_nxt = res_use_val_r;
    cmd             = '0;
    cmd.res_status  = res_status_r;
    cmd.res_use_val = res_use_val_r;
    in_stall        = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_key_byte != 8'd0) begin
            cmd.byte_take = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = S_OCC;
      end
      S_OCC: begin
        cmd.occ_rd = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (sts.word_last) begin
          if (!sts.req_query) begin
            if (!sts.occ || sts.match) begin
              state_nxt = S_WRITE;
            end else if (sts.probe_last) begin
              res_status_nxt  = ST_FULL;
              res_use_val_nxt = 1'b0;
              state_nxt       = S_DONE;
            end else begin
              cmd.probe_next = 1'b1;
              state_nxt      = S_OCC;
            end
          end else begin
            if (!sts.occ || (!sts.match && sts.probe_last)) begin
              res_status_nxt  = ST_NOT_FOUND;
              res_use_val_nxt = 1'b0;
              state_nxt       = S_DONE;
            end else if (sts.match) begin
              res_status_nxt  = ST_OK;
              res_use_val_nxt = 1'b1;
              state_nxt       = S_DONE;
            end else begin
              cmd.probe_next = 1'b1;
              state_nxt      = S_OCC;
            end
          end
        end
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (sts.word_last) begin
          res_status_nxt  = ST_OK;
          res_use_val_nxt = 1'b0;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/skhm_dp.sv =====
`timescale 1ns / 1ps

module skhm_dp #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BYTES   = 63,
  parameter int unsigned VALUE_BITS  = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_req_type,
  input  logic [7:0]      in_key_byte,
  input  logic [63:0]     in_value_in,
  input  logic            out_stall,
  input  skhm_pkg::cmd_t  cmd,
  output skhm_pkg::sts_t  sts,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [63:0]     out_value_out
);
  import skhm_pkg::*;

  localparam int unsigned SW        = $clog2(TABLE_DEPTH);
  localparam int unsigned LW        = $clog2(KEY_BYTES + 1);
  localparam int unsigned KEY_DEPTH = TABLE_DEPTH * KEY_WORDS;
  localparam int unsigned KAW       = SW + 3;
  localparam int unsigned MOD_SH    = 32 + SW;
  localparam int unsigned PW        = MOD_SH + 32;
  localparam longint unsigned MOD_M =
    ((64'd1 << MOD_SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);

  // incoming key
  logic [63:0]           inc_r [KEY_WORDS];
  logic [31:0]           hash_r;
  logic [LW-1:0]         len_r;
  logic                  req_r;
  logic [VALUE_BITS-1:0] val_in_r;
  logic [31:0]           hash_mix;
  logic [63:0]           hash_prod;
  logic [5:0]            pos;

  // probe control
  logic [SW-1:0]         rem_r;
  logic                  mod_cnt_r;
  logic [PW-1:0]         mod_prod_r;
  logic [31:0]           mod_quo;
  logic [31:0]           mod_rem;
  logic [SW-1:0]         probe_r;
  logic [SW-1:0]         clr_r;
  logic [2:0]            w_r;
  logic                  match_r;
  logic [SW-1:0]         slot;
  logic [SW-1:0]         slot_inc;
  logic                  word_eq;

  // stores
  logic [63:0]           key_mem [KEY_DEPTH];
  logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
  logic                  occ_mem [TABLE_DEPTH];
  logic [63:0]           key_q_r;
  logic [VALUE_BITS-1:0] val_q_r;
  logic                  occ_q_r;
  logic [KAW-1:0]        key_ra;
  logic                  occ_we;
  logic [SW-1:0]         occ_wa;

  // output register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [VALUE_BITS-1:0] out_val_r;

  assign hash_mix  = hash_r ^ {24'd0, in_key_byte};
  assign hash_prod = 64'(hash_mix) * 64'(HASH_PRIME);
  assign pos       = 6'(len_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      hash_r <= HASH_BASIS;
      len_r  <= '0;
      for (int i = 0; i < KEY_WORDS; i++) inc_r[i] <= '0;
    end else if (cmd.byte_take) begin
      hash_r <= hash_prod[31:0];
      if (len_r != LW'(KEY_BYTES)) begin
        inc_r[pos[5:3]][{pos[2:0], 3'b000} +: 8] <= in_key_byte;
        len_r <= len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r    <= in_req_type;
      val_in_r <= in_value_in[VALUE_BITS-1:0];
    end
  end

  // hash mod depth by reciprocal multiplication: first the registered scaled
  // product, then hash minus quotient times depth into the slot register
  always_ff @(posedge clk) begin
    if (cmd.mod_step && !mod_cnt_r) mod_prod_r <= PW'(hash_r) * PW'(MOD_M);
  end

  assign mod_quo  = mod_prod_r[MOD_SH +: 32];
  assign mod_rem  = hash_r - mod_quo * 32'(TABLE_DEPTH);
  assign slot     = rem_r;
  assign slot_inc = (slot == SW'(TABLE_DEPTH - 1)) ? '0 : slot + 1'b1;
  assign word_eq  = (key_q_r == inc_r[w_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      mod_cnt_r <= 1'b0;
      rem_r     <= '0;
      probe_r   <= '0;
      w_r       <= '0;
      match_r   <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.start) begin
        mod_cnt_r <= 1'b0;
        rem_r     <= '0;
        probe_r   <= '0;
      end
      if (cmd.mod_step) begin
        mod_cnt_r <= 1'b1;
        if (mod_cnt_r) rem_r <= mod_rem[SW-1:0];
      end
      if (cmd.probe_next) begin
        rem_r   <= slot_inc;
        probe_r <= probe_r + 1'b1;
      end
      if (cmd.occ_rd) begin
        w_r     <= '0;
        match_r <= 1'b1;
      end
      if (cmd.cmp_step) begin
        w_r     <= w_r + 1'b1;
        match_r <= match_r & word_eq;
      end
      if (cmd.wr_step) w_r <= w_r + 1'b1;
    end
  end

  // slot key words: one word read and one written per cycle
  always_comb begin
    key_ra = {slot, 3'd0};
    if (cmd.cmp_step) key_ra = {slot, w_r + 3'd1};
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_step) key_mem[{slot, w_r}] <= inc_r[w_r];
    key_q_r <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_step && w_r == 3'd0) val_mem[slot] <= val_in_r;
    if (cmd.occ_rd) val_q_r <= val_mem[slot];
  end

  assign occ_we = cmd.clr_step || (cmd.wr_step && w_r == 3'd0);
  assign occ_wa = cmd.clr_step ? clr_r : slot;

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= !cmd.clr_step;
    if (cmd.occ_rd) occ_q_r <= occ_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.res_status;
      out_val_r    <= cmd.res_use_val ? val_q_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = 64'(out_val_r);

  assign sts.clr_done   = (clr_r == SW'(TABLE_DEPTH - 1));
  assign sts.mod_done   = mod_cnt_r;
  assign sts.word_last  = (w_r == 3'd7);
  assign sts.probe_last = (probe_r == SW'(TABLE_DEPTH - 1));
  assign sts.occ        = occ_q_r;
  assign sts.match      = match_r & word_eq;
  assign sts.req_query  = req_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

// ===== hw/rtl/string_key_hash_map.sv =====
`timescale 1ns / 1ps

// channel | direction | ports
// --------+-----------+------------------------------------------------------
// in      | input     | in_valid, in_stall, in_req_type, in_key_byte, in_value_in
// out     | output    | out_valid, out_stall, out_status, out_value_out
//
// a nonzero key byte is taken while idle; a zero byte starts the request
// request: hash mod depth, then per probed slot one occupied/value read and
//   eight key word compares on the key ram read port, then key word writes for
//   a publish that finds a free or matching slot, and last the result load
// after reset a clearing pass over all TABLE_DEPTH slots holds in_stall high
// a loaded result does not block new key bytes; in_stall is low only when idle
module string_key_hash_map #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BYTES   = 63,
  parameter int unsigned VALUE_BITS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_key_byte,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_value_out
);
  import skhm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, key collection, probe loop, result hand-off
  skhm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_key_byte (in_key_byte),
    .sts         (sts),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  // hash, key buffer, modulo unit, slot stores and the output register
  skhm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_req_type),
    .in_key_byte   (in_key_byte),
    .in_value_in   (in_value_in),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_value_out (out_value_out)
  );

`ifndef SYNTH
  // a terminating byte puts the block to work
  a_busy_after_term: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_key_byte == 8'd0) |=> in_stall)
    else $error("took an item straight after a terminating byte");

  // value only travels with a successful result
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_value_out == 64'd0)
    else $error("nonzero value with a failing status");

  // the clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall)
    else $error("input open during clearing pass");

  // datapath sees at most one work command a cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.mod_step, cmd.occ_rd, cmd.cmp_step,
              cmd.wr_step, cmd.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== tb/tb_string_key_hash_map.sv =====
`timescale 1ns / 1ps

module tb_string_key_hash_map;
  import skhm_pkg::*;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned KBYTES  = 63;
  localparam int unsigned KWORDS  = 8;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic        REQ_PUBLISH = 1'b0;
  localparam logic        REQ_QUERY   = 1'b1;
  localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

  // idling phases
  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [7:0]  in_key_byte;
  logic [63:0] in_value_in;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [63:0] out_value_out;

  string_key_hash_map dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_key_byte  (in_key_byte),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_value_out(out_value_out)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the table
  logic        tbl_used [DEPTH];
  logic [63:0] tbl_key  [DEPTH][KWORDS];
  logic [63:0] tbl_val  [DEPTH];
  // key under assembly
  logic [63:0] cur_key  [KWORDS];
  logic [31:0] cur_hash;
  int unsigned cur_len;

  typedef struct packed {
    status_t     status;
    logic [63:0] value;
  } reply_t;

  reply_t pending_replies[$];

  idle_phase_t phase;
  logic        hold_off;
  int          mismatches;
  bit          failed;
  longint unsigned cycle_count;
  int          replies_seen;

  // one accepted item through the shadow table; returns 1 when a reply is due
  function automatic bit map_accept(input logic rq, input logic [7:0] kb,
                                    input logic [63:0] val, output reply_t r);
    int unsigned slot;
    bit hit;
    bit stop;
    r.status = ST_OK;
    r.value  = '0;
    if (kb != 8'd0) begin
      cur_hash = (cur_hash ^ {24'd0, kb}) * FNV_PRIME;
      if (cur_len < KBYTES) begin
        cur_key[cur_len / 8][(cur_len % 8) * 8 +: 8] = kb;
        cur_len++;
      end
      return 1'b0;
    end
    slot = cur_hash % DEPTH;
    stop = 1'b0;
    hit  = 1'b0;
    for (int p = 0; p < DEPTH && !stop; p++) begin
      bit same;
      same = tbl_used[slot];
      for (int w = 0; w < KWORDS; w++)
        if (tbl_key[slot][w] !== cur_key[w]) same = 1'b0;
      if (rq == REQ_PUBLISH) begin
        if (!tbl_used[slot] || same) begin
          for (int w = 0; w < KWORDS; w++) tbl_key[slot][w] = cur_key[w];
          tbl_val[slot]  = val;
          tbl_used[slot] = 1'b1;
          hit  = 1'b1;
          stop = 1'b1;
        end
      end else begin
        if (!tbl_used[slot]) begin
          stop = 1'b1;
        end else if (same) begin
          r.value = tbl_val[slot];
          hit  = 1'b1;
          stop = 1'b1;
        end
      end
      slot = (slot + 1) % DEPTH;
    end
    if (!hit) r.status = (rq == REQ_QUERY) ? ST_NOT_FOUND : ST_FULL;
    for (int w = 0; w < KWORDS; w++) cur_key[w] = '0;
    cur_hash = FNV_BASIS;
    cur_len  = 0;
    return 1'b1;
  endfunction

  function automatic bit sender_idles();
    case (phase)
      PH_SEND, PH_BOTH: return $urandom_range(99) < (phase == PH_SEND ? 79 : 10);
      default: return 1'b0;
    endcase
  endfunction

  // receiver stall, redrawn every cycle; hold_off forces a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      case (phase)
        PH_RECV: out_stall <= ($urandom_range(99) < 79);
        PH_BOTH: out_stall <= ($urandom_range(99) < 10);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // result checker: field by field against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      reply_t e;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d value %h", out_status, out_value_out);
      end else begin
        e = pending_replies.pop_front();
        if (out_status !== e.status || out_value_out !== e.value) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                     e.status, out_status, e.value, out_value_out);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // long receiver hold-off, counted here, while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    wait (replies_seen >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one item and wait for acceptance; prediction happens on acceptance
  task automatic offer_item(input logic rq, input logic [7:0] kb, input logic [63:0] val,
                            input bit typed, input reply_t typed_reply);
    reply_t r;
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rq;
    in_key_byte <= kb;
    in_value_in <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (map_accept(rq, kb, val, r)) begin
      // typed rows must agree with the shadow table too
      if (typed && r !== typed_reply) begin
        failed = 1'b1;
        $display("directed row disagrees with shadow table");
      end
      pending_replies.push_back(r);
    end
  endtask

  // a whole key followed by its terminating byte
  task automatic send_request(input logic rq, input string k, input logic [63:0] val,
                              input bit typed, input reply_t typed_reply);
    reply_t none;
    none = '0;
    for (int i = 0; i < k.len(); i++)
      offer_item($urandom_range(1), k[i], {$urandom, $urandom}, 1'b0, none);
    offer_item(rq, 8'd0, val, typed, typed_reply);
  endtask

  // directed rows: key, request, value, and a typed reply where obvious
  typedef struct {
    string       key_text;
    logic        rq;
    logic [63:0] val;
    bit          typed;
    status_t     st;
    logic [63:0] v;
  } stim_row_t;

  stim_row_t directed[$];
  string long_a, long_b, pool[$];

  initial begin
    reply_t tr;
    string  k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = 1'b0;
    in_key_byte = 8'd0;
    in_value_in = '0;
    phase       = PH_NONE;
    mismatches  = 0;
    failed      = 1'b0;
    cycle_count = 0;
    replies_seen = 0;
    for (int s = 0; s < DEPTH; s++) begin
      tbl_used[s] = 1'b0;
      tbl_val[s]  = '0;
      for (int w = 0; w < KWORDS; w++) tbl_key[s][w] = '0;
    end
    for (int w = 0; w < KWORDS; w++) cur_key[w] = '0;
    cur_hash = FNV_BASIS;
    cur_len  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // long keys: differ only past the buffered bytes, so their stored keys compare equal though their hashes differ
    long_a = "";
    for (int i = 0; i < 70; i++) long_a = {long_a, "x"};
    long_b = {long_a.substr(0, 64), "zzzzz"};

    // empty table misses, empty key, extremes of value and byte
    directed.push_back('{"", REQ_QUERY, 64'd0, 1'b1, ST_NOT_FOUND, 64'd0});
    directed.push_back('{"abc", REQ_QUERY, 64'd0, 1'b1, ST_NOT_FOUND, 64'd0});
    directed.push_back('{"", REQ_PUBLISH, '1, 1'b1, ST_OK, 64'd0});
    directed.push_back('{"", REQ_QUERY, 64'd0, 1'b1, ST_OK, '1});
    directed.push_back('{"abc", REQ_PUBLISH, 64'd0, 1'b1, ST_OK, 64'd0});
    directed.push_back('{"abc", REQ_QUERY, '1, 1'b1, ST_OK, 64'd0});
    directed.push_back('{"abc", REQ_PUBLISH, 64'h0123_4567_89ab_cdef, 1'b1, ST_OK, 64'd0});
    directed.push_back('{"abc", REQ_QUERY, 64'd0, 1'b0, ST_OK, 64'd0});
    directed.push_back('{"\xff\x01\x80\x7f", REQ_PUBLISH, 64'h8000_0000_0000_0001,
                         1'b1, ST_OK, 64'd0});
    directed.push_back('{"\xff\x01\x80\x7f", REQ_QUERY, 64'd0, 1'b0, ST_OK, 64'd0});
    directed.push_back('{long_a, REQ_PUBLISH, 64'h5555_aaaa_5555_aaaa, 1'b1, ST_OK, 64'd0});
    directed.push_back('{long_b, REQ_QUERY, 64'd0, 1'b0, ST_OK, 64'd0});
    directed.push_back('{"abd", REQ_QUERY, 64'd0, 1'b0, ST_OK, 64'd0});
    foreach (directed[i]) begin
      tr.status = directed[i].st;
      tr.value  = directed[i].v;
      send_request(directed[i].rq, directed[i].key_text, directed[i].val,
                   directed[i].typed, tr);
    end

    // random part over the idling phases; keys from a small pool so queries hit
    for (int ph = 0; ph < 4; ph++) begin
      phase = idle_phase_t'(ph);
      for (int n = 0; n < 4; n++) begin
        int len;
        reply_t none;
        none = '0;
        if (pool.size() > 0 && $urandom_range(99) < 60) begin
          k = pool[$urandom_range(pool.size() - 1)];
        end else begin
          len = ($urandom_range(9) == 0) ? $urandom_range(64, 70) : $urandom_range(0, 6);
          k = "";
          for (int i = 0; i < len; i++) k = {k, string'(byte'($urandom_range(1, 255)))};
          if (pool.size() < 40) pool.push_back(k);
        end
        send_request($urandom_range(1), k, {$urandom, $urandom}, 1'b0, none);
      end
    end

    // fill the table with one-byte keys so publishes report full and queries wrap
    phase = PH_NONE;
    for (int n = 1; n < 256; n++) begin
      reply_t none;
      none = '0;
      k = string'(byte'(n));
      send_request(REQ_PUBLISH, k, {$urandom, $urandom}, 1'b0, none);
      if (n % 64 == 0) send_request(REQ_QUERY, "missing!", 64'd0, 1'b0, none);
    end
    for (int n = 0; n < 4; n++) begin
      reply_t none;
      none = '0;
      k = $sformatf("z%0d", n);
      send_request(REQ_PUBLISH, k, {$urandom, $urandom}, 1'b0, none);
    end
    send_request(REQ_QUERY, "nope", 64'd0, 1'b0, tr);

    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DEPTH * 10 + 100) @(posedge clk);
    if (!failed && mismatches == 0 && pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
